@@ rtl/sbc_pkg.sv @@
// ----------------------------------------------------------------------------
// sbc_pkg: segment box clip package
// default widths and edge count for the clipping pipeline
// ----------------------------------------------------------------------------
package sbc_pkg;

    localparam int DEFAULT_COORD_WIDTH         = 24;
    localparam int DEFAULT_PARAM_FRACTION_BITS = 16;
    localparam int NUM_EDGES                   = 4;

    typedef enum logic [1:0] {
        EDGE_LEFT   = 2'd0,
        EDGE_RIGHT  = 2'd1,
        EDGE_BOTTOM = 2'd2,
        EDGE_TOP    = 2'd3
    } edge_t;

endpackage

@@ rtl/segment_box_clip.sv @@
// ----------------------------------------------------------------------------
// segment_box_clip: 2d segment against box clipper
// liang-barsky clip of one segment against a centre/half-extent box per word
// ----------------------------------------------------------------------------
// throughput: one word per cycle unless m_tready stalls, set by one quotient bit per
//   stage in the four parallel divider lanes
// each stage holds its word until the next one is free, so bubbles collapse
// reset clears all valid bits, payload registers are not reset
module segment_box_clip
    import sbc_pkg::*;
#(
    parameter int COORD_WIDTH         = DEFAULT_COORD_WIDTH,
    parameter int PARAM_FRACTION_BITS = DEFAULT_PARAM_FRACTION_BITS,
    localparam int IN_BITS  = 6 * COORD_WIDTH + 2 * (COORD_WIDTH - 1),
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS = 1 + 2 * (PARAM_FRACTION_BITS + 1),
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // start_x, start_y, end_x, end_y, box_center_x, box_center_y,
    // box_half_x, box_half_y, zero fill
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // hit, enter_param, leave_param, zero fill
    output logic [OUT_W-1:0] m_tdata
);

    localparam int W   = COORD_WIDTH;
    localparam int F   = PARAM_FRACTION_BITS;
    localparam int PW  = W + 1;
    localparam int QW  = W + 2;
    localparam int UW  = F + 1;
    localparam int TW  = F + 3;
    localparam int ND  = F + 1;
    localparam int NS  = ND + 3;
    localparam int NE  = NUM_EDGES;
    localparam logic [UW-1:0] U_CLAMP = UW'((1 << F) + 1);
    localparam logic signed [TW-1:0] T_ONE = TW'(1 << F);

    // input unpack
    logic signed [W-1:0] start_x, start_y, end_x, end_y, box_center_x, box_center_y;
    logic [W-2:0]        box_half_x, box_half_y;

    assign start_x      = s_tdata[0*W +: W];
    assign start_y      = s_tdata[1*W +: W];
    assign end_x        = s_tdata[2*W +: W];
    assign end_y        = s_tdata[3*W +: W];
    assign box_center_x = s_tdata[4*W +: W];
    assign box_center_y = s_tdata[5*W +: W];
    assign box_half_x   = s_tdata[6*W +: W-1];
    assign box_half_y   = s_tdata[6*W+W-1 +: W-1];

    // stage flow control
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] ce;

    always_comb
    begin
        ce[NS-1] = !vld_reg[NS-1] || m_tready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            ce[i] = !vld_reg[i] || ce[i+1];
        end
    end

    assign s_tready = ce[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (ce[0])
            begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (ce[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // stage a: direction and offset terms
    logic signed [QW-1:0] sxe, sye, exe, eye, cxe, cye, hxe, hye;
    logic signed [PW-1:0] p_next [NE];
    logic signed [QW-1:0] q_next [NE];
    logic signed [PW-1:0] p_reg  [NE];
    logic signed [QW-1:0] q_reg  [NE];

    assign sxe = QW'(start_x);
    assign sye = QW'(start_y);
    assign exe = QW'(end_x);
    assign eye = QW'(end_y);
    assign cxe = QW'(box_center_x);
    assign cye = QW'(box_center_y);
    assign hxe = QW'($signed({1'b0, box_half_x}));
    assign hye = QW'($signed({1'b0, box_half_y}));

    always_comb
    begin
        p_next[EDGE_LEFT]   = PW'(sxe - exe);
        q_next[EDGE_LEFT]   = sxe - cxe + hxe;
        p_next[EDGE_RIGHT]  = PW'(exe - sxe);
        q_next[EDGE_RIGHT]  = cxe + hxe - sxe;
        p_next[EDGE_BOTTOM] = PW'(sye - eye);
        q_next[EDGE_BOTTOM] = sye - cye + hye;
        p_next[EDGE_TOP]    = PW'(eye - sye);
        q_next[EDGE_TOP]    = cye + hye - sye;
    end

    always_ff @(posedge clk)
    begin
        if (ce[0])
        begin
            p_reg <= p_next;
            q_reg <= q_next;
        end
    end

    // divider lanes: index 0 is the prepared word, index k after k bits
    logic [QW-1:0] r_reg   [0:ND][NE];
    logic [UW-1:0] u_reg   [0:ND][NE];
    logic [PW-1:0] ap_reg  [0:ND][NE];
    logic          pz_reg  [0:ND][NE];
    logic          pn_reg  [0:ND][NE];
    logic          qn_reg  [0:ND][NE];
    logic          ovf_reg [0:ND][NE];

    // stage b: magnitudes, signs and range check
    always_ff @(posedge clk)
    begin
        if (ce[1])
        begin
            for (int e = 0; e < NE; e++)
            begin
                r_reg[0][e]   <= q_reg[e][QW-1] ? QW'(-q_reg[e]) : QW'(q_reg[e]);
                ap_reg[0][e]  <= p_reg[e][PW-1] ? PW'(-p_reg[e]) : PW'(p_reg[e]);
                u_reg[0][e]   <= '0;
                pz_reg[0][e]  <= (p_reg[e] == '0);
                pn_reg[0][e]  <= p_reg[e][PW-1];
                qn_reg[0][e]  <= q_reg[e][QW-1];
                ovf_reg[0][e] <= (q_reg[e][QW-1] ? QW'(-q_reg[e]) : QW'(q_reg[e]))
                              >= {(p_reg[e][PW-1] ? PW'(-p_reg[e]) : PW'(p_reg[e])), 1'b0};
            end
        end
    end

    genvar k;
    generate
        for (k = 0; k < ND; k++)
        begin : g_div
            logic [QW-1:0] rs     [NE];
            logic [QW-1:0] r_next [NE];
            logic          b_next [NE];

            always_comb
            begin
                for (int e = 0; e < NE; e++)
                begin
                    rs[e] = (k == 0) ? r_reg[k][e] : {r_reg[k][e][QW-2:0], 1'b0};
                    b_next[e] = rs[e] >= QW'(ap_reg[k][e]);
                    r_next[e] = b_next[e] ? rs[e] - QW'(ap_reg[k][e]) : rs[e];
                end
            end

            always_ff @(posedge clk)
            begin
                if (ce[k+2])
                begin
                    for (int e = 0; e < NE; e++)
                    begin
                        r_reg[k+1][e]   <= r_next[e];
                        u_reg[k+1][e]   <= {u_reg[k][e][UW-2:0], b_next[e]};
                        ap_reg[k+1][e]  <= ap_reg[k][e];
                        pz_reg[k+1][e]  <= pz_reg[k][e];
                        pn_reg[k+1][e]  <= pn_reg[k][e];
                        qn_reg[k+1][e]  <= qn_reg[k][e];
                        ovf_reg[k+1][e] <= ovf_reg[k][e];
                    end
                end
            end
        end
    endgenerate

    // last stage: interval update over the left, right, bottom and top edges in order
    logic                 hit_next;
    logic signed [TW-1:0] lo_next, hi_next;
    logic [UW-1:0]        us;
    logic signed [TW-1:0] t;
    logic                 hit_reg;
    logic [UW-1:0]        enter_reg, leave_reg;

    always_comb
    begin
        hit_next = 1'b1;
        lo_next  = '0;
        hi_next  = T_ONE;
        us       = '0;
        t        = '0;
        for (int e = 0; e < NE; e++)
        begin
            us = (ovf_reg[ND][e] || u_reg[ND][e] > U_CLAMP) ? U_CLAMP : u_reg[ND][e];
            if (pn_reg[ND][e] ^ qn_reg[ND][e])
            begin
                t = (us != '0) ? -TW'(1) : '0;
            end
            else
            begin
                t = TW'(us);
            end
            if (pz_reg[ND][e])
            begin
                if (qn_reg[ND][e])
                begin
                    hit_next = 1'b0;
                end
            end
            else if (pn_reg[ND][e])
            begin
                if (t > hi_next)
                begin
                    hit_next = 1'b0;
                end
                else if (t > lo_next)
                begin
                    lo_next = t;
                end
            end
            else
            begin
                if (t < lo_next)
                begin
                    hit_next = 1'b0;
                end
                else if (t < hi_next)
                begin
                    hi_next = t;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce[NS-1])
        begin
            hit_reg   <= hit_next;
            enter_reg <= hit_next ? lo_next[UW-1:0] : '0;
            leave_reg <= hit_next ? hi_next[UW-1:0] : '0;
        end
    end

    assign m_tvalid = vld_reg[NS-1];
    assign m_tdata  = OUT_W'({leave_reg, enter_reg, hit_reg});

endmodule
